>>> hdl/ksl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keyed slot table package
// Request and response types, status and opcode codes, configuration
// register indexes and reset values shared by the keyed slot table modules.
// ----------------------------------------------------------------------------
package ksl_pkg;

  localparam int KeyWidth = 17;
  localparam int CfgWidth = 3;
  localparam int NumCfg   = 4;

  localparam logic [KeyWidth-1:0] KEY_MIN   = 17'd10000;
  localparam logic [KeyWidth-1:0] KEY_MAX   = 17'd99999;
  localparam logic [KeyWidth-1:0] KEY_EMPTY = 17'd0;

  // Opcodes. The unused code decodes as a search.
  localparam logic [1:0] OP_CLAIM   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_SEARCH  = 2'd2;

  // Response status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_KEY   = 3'd1;
  localparam logic [2:0] ST_PRESENT   = 3'd2;
  localparam logic [2:0] ST_BAD_LOC   = 3'd3;
  localparam logic [2:0] ST_OCCUPIED  = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;

  // Configuration register indexes.
  localparam logic [7:0] CFG_GROUP0_SLOTS = 8'd0;
  localparam logic [7:0] CFG_GROUP1_SLOTS = 8'd1;
  localparam logic [7:0] CFG_GROUP2_SLOTS = 8'd2;
  localparam logic [7:0] CFG_GROUP3_SLOTS = 8'd3;

  localparam logic [CfgWidth-1:0] GROUP0_SLOTS_RST = 3'd5;
  localparam logic [CfgWidth-1:0] GROUP1_SLOTS_RST = 3'd6;
  localparam logic [CfgWidth-1:0] GROUP2_SLOTS_RST = 3'd4;
  localparam logic [CfgWidth-1:0] GROUP3_SLOTS_RST = 3'd3;

  typedef logic [NumCfg-1:0][CfgWidth-1:0] ksl_sizes_t;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [KeyWidth-1:0] user_key;
    logic [1:0]          group_index;
    logic [2:0]          slot_index;
  } ksl_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [1:0] found_group;
    logic [2:0] found_slot;
  } ksl_rsp_t;

  typedef struct packed {
    logic                en;
    logic [7:0]          index;
    logic [CfgWidth-1:0] data;
  } ksl_cfg_wr_t;

endpackage
`default_nettype wire

>>> hdl/ksl_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keyed slot table configuration registers
// Holds the usable slot count of each register-backed group.
// ----------------------------------------------------------------------------
module ksl_cfg (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ksl_pkg::ksl_cfg_wr_t wr,
  output ksl_pkg::ksl_sizes_t       group_sizes
);

  ksl_pkg::ksl_sizes_t sizes;

  always_ff @(posedge clk) begin
    if (rst) begin
      sizes[0] <= ksl_pkg::GROUP0_SLOTS_RST;
      sizes[1] <= ksl_pkg::GROUP1_SLOTS_RST;
      sizes[2] <= ksl_pkg::GROUP2_SLOTS_RST;
      sizes[3] <= ksl_pkg::GROUP3_SLOTS_RST;
    end else if (wr.en) begin
      // Writes to indexes past the last register are dropped.
      case (wr.index)
        ksl_pkg::CFG_GROUP0_SLOTS: sizes[0] <= wr.data;
        ksl_pkg::CFG_GROUP1_SLOTS: sizes[1] <= wr.data;
        ksl_pkg::CFG_GROUP2_SLOTS: sizes[2] <= wr.data;
        ksl_pkg::CFG_GROUP3_SLOTS: sizes[3] <= wr.data;
        default: ;
      endcase
    end
  end

  assign group_sizes = sizes;

endmodule
`default_nettype wire

>>> hdl/ksl_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keyed slot table storage and lookup
// Slot key registers, parallel key compare, first-match priority select,
// claim checks and the table update for one request per cycle while step is high.
// ----------------------------------------------------------------------------
module ksl_table #(
  parameter int NUM_GROUPS = 4,
  parameter int MAX_SLOTS  = 6
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire ksl_pkg::ksl_req_t   req,
  input  wire ksl_pkg::ksl_sizes_t group_sizes,
  output ksl_pkg::ksl_rsp_t        rsp
);

  localparam int GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int NumSlots = NUM_GROUPS * MAX_SLOTS;
  localparam logic [4:0] MaxSlotsW  = 5'(MAX_SLOTS);
  localparam logic [4:0] NumGroupsW = 5'(NUM_GROUPS);

  logic [ksl_pkg::KeyWidth-1:0] slot_keys [NUM_GROUPS][MAX_SLOTS];

  logic [NumSlots-1:0] match_flat;
  logic [NumSlots-1:0] first_flat;
  logic [NumSlots-1:0] claim_flat;
  logic                hit;
  logic [GW-1:0]       hit_g;
  logic [SW-1:0]       hit_s;
  logic                key_ok;
  logic                is_claim;
  logic                is_release;
  logic                is_search;
  logic [2:0]          size_raw;
  logic [4:0]          usable;
  logic                loc_ok;
  logic                occupied;
  logic                do_claim;
  logic                do_release;

  assign key_ok = (req.user_key >= ksl_pkg::KEY_MIN) && (req.user_key <= ksl_pkg::KEY_MAX);
  assign is_claim   = (req.opcode == ksl_pkg::OP_CLAIM);
  assign is_release = (req.opcode == ksl_pkg::OP_RELEASE);
  assign is_search  = !is_claim && !is_release;

  // Compare every slot and keep the first match in group-then-slot order.
  always_comb begin
    logic seen;
    seen = 1'b0;
    hit_g = '0;
    hit_s = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      for (int s = 0; s < MAX_SLOTS; s++) begin
        match_flat[g*MAX_SLOTS+s] = (slot_keys[g][s] == req.user_key);
        first_flat[g*MAX_SLOTS+s] = match_flat[g*MAX_SLOTS+s] && !seen;
        if (match_flat[g*MAX_SLOTS+s] && !seen) begin
          hit_g = GW'(g);
          hit_s = SW'(s);
        end
        seen = seen | match_flat[g*MAX_SLOTS+s];
      end
    end
    hit = seen;
  end

  // Usable size of the claimed group, saturated to the slots that exist.
  assign size_raw = group_sizes[req.group_index];
  assign usable   = ({2'b00, size_raw} > MaxSlotsW) ? MaxSlotsW : {2'b00, size_raw};
  assign loc_ok   = (5'(req.group_index) < NumGroupsW) && (5'(req.slot_index) < usable);

  always_comb begin
    occupied = 1'b0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      for (int s = 0; s < MAX_SLOTS; s++) begin
        claim_flat[g*MAX_SLOTS+s] = (5'(g) == 5'(req.group_index)) &&
                                    (5'(s) == 5'(req.slot_index));
        if (claim_flat[g*MAX_SLOTS+s]) begin
          occupied = (slot_keys[g][s] != ksl_pkg::KEY_EMPTY);
        end
      end
    end
  end

  assign do_claim   = key_ok && is_claim && !hit && loc_ok && !occupied;
  assign do_release = key_ok && is_release && hit;

  always_comb begin
    rsp = '0;
    if (!key_ok) begin
      rsp.status = ksl_pkg::ST_BAD_KEY;
    end else if (is_claim) begin
      if (hit) begin
        rsp.status = ksl_pkg::ST_PRESENT;
      end else if (!loc_ok) begin
        rsp.status = ksl_pkg::ST_BAD_LOC;
      end else if (occupied) begin
        rsp.status = ksl_pkg::ST_OCCUPIED;
      end else begin
        rsp.status = ksl_pkg::ST_OK;
      end
    end else if (!hit) begin
      rsp.status = ksl_pkg::ST_NOT_FOUND;
    end else begin
      rsp.status = ksl_pkg::ST_OK;
      if (is_search) begin
        rsp.found_group = 2'(hit_g);
        rsp.found_slot  = 3'(hit_s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        for (int s = 0; s < MAX_SLOTS; s++) begin
          slot_keys[g][s] <= ksl_pkg::KEY_EMPTY;
        end
      end
    end else if (step) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        for (int s = 0; s < MAX_SLOTS; s++) begin
          if (do_claim && claim_flat[g*MAX_SLOTS+s]) begin
            slot_keys[g][s] <= req.user_key;
          end else if (do_release && first_flat[g*MAX_SLOTS+s]) begin
            slot_keys[g][s] <= ksl_pkg::KEY_EMPTY;
          end
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  // A valid key is only ever stored once, since a claim checks for it first.
  a_key_unique: assert property (@(posedge clk) disable iff (rst)
    key_ok |-> $onehot0(match_flat))
    else $error("valid key stored in more than one slot");

  // Only a successful search reports a location.
  a_found_zero: assert property (@(posedge clk) disable iff (rst)
    !(is_search && rsp.status == ksl_pkg::ST_OK) |->
      (rsp.found_group == 2'd0 && rsp.found_slot == 3'd0))
    else $error("location reported outside a successful search");

  // A claimed key is present in the table after the update.
  a_claim_lands: assert property (@(posedge clk) disable iff (rst)
    (step && do_claim) ##1 (req.user_key == $past(req.user_key)) |-> hit)
    else $error("claimed key missing after update");
`endif

endmodule
`default_nettype wire

>>> hdl/keyed_slot_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keyed slot table
// Content-addressed table of groups of slots holding five-digit keys, with
// claim, release and search requests and a per-group usable slot count.
// ----------------------------------------------------------------------------
//
//   channel   signals                         payload
//   --------  ------------------------------  -----------------------------
//   req       req_valid / req_stall           req_data  (ksl_req_t)
//   rsp       rsp_valid / rsp_stall           rsp_data  (ksl_rsp_t)
//   cfg       cfg_valid / cfg_ready           cfg_index, cfg_data
//
// One request can be taken every cycle unless rsp_stall holds a response,
// a rate set by the combinational compare of the key against every slot.
// A request is held in the input register and its response then in the
// response register. Reset (synchronous, active high) empties every slot
// and reloads the group sizes at once, with no clearing pass. req_stall is
// high only while both registers are full and rsp_stall holds the response.
// ----------------------------------------------------------------------------
module keyed_slot_table #(
  parameter int NUM_GROUPS = 4,
  parameter int MAX_SLOTS  = 6
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            req_valid,
  output logic                                 req_stall,
  input  wire ksl_pkg::ksl_req_t               req_data,
  output logic                                 rsp_valid,
  input  wire logic                            rsp_stall,
  output ksl_pkg::ksl_rsp_t                    rsp_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [7:0]                      cfg_index,
  input  wire logic [ksl_pkg::CfgWidth-1:0]    cfg_data
);

  // Input register holding the request under work.
  logic              s1_valid;
  logic              s1_valid_next;
  ksl_pkg::ksl_req_t s1_req;

  logic              rsp_valid_next;
  logic              accept_in;
  logic              advance;

  ksl_pkg::ksl_rsp_t   table_rsp;
  ksl_pkg::ksl_sizes_t group_sizes;
  ksl_pkg::ksl_cfg_wr_t cfg_wr;

  // Configuration writes are always taken.
  assign cfg_ready    = 1'b1;
  assign cfg_wr.en    = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  ksl_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .wr          (cfg_wr),
    .group_sizes (group_sizes)
  );

  // The request in the input register finishes, and updates the table, in
  // the cycle it moves into the response register.
  assign advance   = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && !advance;
  assign accept_in = req_valid && !req_stall;

  ksl_table #(
    .NUM_GROUPS (NUM_GROUPS),
    .MAX_SLOTS  (MAX_SLOTS)
  ) u_table (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .req         (s1_req),
    .group_sizes (group_sizes),
    .rsp         (table_rsp)
  );

  always_comb begin
    s1_valid_next = s1_valid;
    if (accept_in) begin
      s1_valid_next = 1'b1;
    end else if (advance) begin
      s1_valid_next = 1'b0;
    end
    rsp_valid_next = rsp_valid;
    if (advance) begin
      rsp_valid_next = 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      s1_valid  <= s1_valid_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      s1_req <= req_data;
    end
    if (advance) begin
      rsp_data <= table_rsp;
    end
  end

`ifndef NO_ASSERTIONS
  // Back-pressure only appears when both registers hold work.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (s1_valid && rsp_valid && rsp_stall))
    else $error("request stalled with room in the pipeline");

  // A request in the input register always moves into the response register
  // when that register is empty.
  a_request_moves: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !rsp_valid) |=> rsp_valid)
    else $error("request in input register did not advance");

  // A response leaves only through a taken handshake.
  a_rsp_kept: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> rsp_valid)
    else $error("stalled response dropped");
`endif

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed slot table testbench
// Sends claim, release and search requests into the table. Valid gaps and
// response stalls are random. A behavioral copy of the slot keys and group
// sizes predicts every response, and each response is compared field by
// field, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import ksl_pkg::*;

  localparam int NUM_GROUPS  = 4;
  localparam int MAX_SLOTS   = 6;
  localparam int NUM_ENTRIES = NUM_GROUPS * MAX_SLOTS;
  // An accepted request passes through the input register and then the response register.
  localparam int RSP_LATENCY = 2;
  localparam int POOL_SIZE   = 32;
  localparam int PHASE_ITEMS = 150;
  localparam int NUM_PHASES  = 7;

  // The fourth opcode has no meaning of its own. It decodes as a search.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Register indexes that have no register behind them.
  localparam logic [7:0] CFG_UNUSED_FIRST = 8'd4;
  localparam logic [7:0] CFG_UNUSED_LAST  = 8'd255;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_stall;
  ksl_req_t            req_data  = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  ksl_rsp_t            rsp_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [7:0]          cfg_index = '0;
  logic [CfgWidth-1:0] cfg_data  = '0;

  // Predicted contents of the table. The flat index is group * MAX_SLOTS + slot.
  logic [KeyWidth-1:0] table_keys [NUM_ENTRIES];
  logic [CfgWidth-1:0] group_size [NumCfg];
  // Predicted responses, oldest first.
  ksl_rsp_t            expected_rsp [$];
  // A small set of keys that keeps random traffic colliding with itself.
  logic [KeyWidth-1:0] key_pool [POOL_SIZE];
  int                  error_count   = 0;
  // When this is set, neither the sender nor the receiver inserts gaps.
  bit                  no_idle       = 1'b0;
  int                  rsp_hold_left = 0;

  keyed_slot_table #(
    .NUM_GROUPS(NUM_GROUPS),
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_data (rsp_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // Gap length for either side of the block. Most gaps are short, a few are
  // long enough to fill the pipeline and push stall back to the sender.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // A size register above MAX_SLOTS saturates. A group with no register
  // behind it gets the full MAX_SLOTS.
  function automatic int usable_slots(input logic [1:0] grp);
    int n;
    if (grp >= NumCfg) return MAX_SLOTS;
    n = group_size[grp];
    if (n > MAX_SLOTS) n = MAX_SLOTS;
    return n;
  endfunction

  // Returns the first flat index that holds the key, scanning by group and
  // then by slot. Slots beyond a group's size are scanned too. Returns -1
  // when no slot holds the key.
  function automatic int locate_key(input logic [KeyWidth-1:0] key);
    for (int i = 0; i < NUM_ENTRIES; i++)
      if (table_keys[i] == key) return i;
    return -1;
  endfunction

  // Works out the response to one request and applies its effect to the
  // predicted table.
  function automatic ksl_rsp_t apply_request(input ksl_req_t r);
    ksl_rsp_t rsp;
    int       hit;
    int       flat;
    rsp = '0;
    hit = locate_key(r.user_key);
    if (r.user_key < KEY_MIN || r.user_key > KEY_MAX) begin
      // An out-of-range key is refused for every opcode.
      rsp.status = ST_BAD_KEY;
    end else if (r.opcode == OP_CLAIM) begin
      // The order of claim checks matters: already present comes before
      // bad location, and bad location before occupied.
      if (hit >= 0) begin
        rsp.status = ST_PRESENT;
      end else if (r.group_index >= NUM_GROUPS ||
                   r.slot_index >= usable_slots(r.group_index)) begin
        rsp.status = ST_BAD_LOC;
      end else begin
        flat = r.group_index * MAX_SLOTS + r.slot_index;
        if (table_keys[flat] != KEY_EMPTY) begin
          rsp.status = ST_OCCUPIED;
        end else begin
          table_keys[flat] = r.user_key;
          rsp.status = ST_OK;
        end
      end
    end else if (r.opcode == OP_RELEASE) begin
      if (hit < 0) begin
        rsp.status = ST_NOT_FOUND;
      end else begin
        table_keys[hit] = KEY_EMPTY;
        rsp.status = ST_OK;
      end
    end else begin
      // This branch handles both the search opcode and the unused opcode.
      if (hit < 0) begin
        rsp.status = ST_NOT_FOUND;
      end else begin
        rsp.status      = ST_OK;
        rsp.found_group = 2'(hit / MAX_SLOTS);
        rsp.found_slot  = 3'(hit % MAX_SLOTS);
      end
    end
    return rsp;
  endfunction

  function automatic logic [CfgWidth-1:0] pick_size();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return CfgWidth'($urandom_range(1, MAX_SLOTS));
  endfunction

  // Most keys come from the pool. Some are fresh valid keys or the range
  // limits. The rest are out of range on either side.
  function automatic logic [KeyWidth-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 78) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (r < 88) return KeyWidth'($urandom_range(KEY_MIN, KEY_MAX));
    if (r < 90) return r[0] ? KEY_MIN : KEY_MAX;
    if (r < 95) return KeyWidth'($urandom_range(0, KEY_MIN - 1));
    return KeyWidth'($urandom_range(KEY_MAX + 1, 2**KeyWidth - 1));
  endfunction

  // Sends one request after a random gap. The request is accepted at the
  // first rising edge where stall is low. Valid stays high on return, so a
  // request that follows with no gap goes out in the very next cycle.
  task automatic send_req(input logic [1:0] op, input logic [KeyWidth-1:0] key,
                          input logic [1:0] grp, input logic [2:0] slot);
    ksl_req_t r;
    int       gap;
    r.opcode      = op;
    r.user_key    = key;
    r.group_index = grp;
    r.slot_index  = slot;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    expected_rsp.push_back(apply_request(r));
  endtask

  // Stops sending and waits until every outstanding response has arrived.
  // Each request gives a response, so an empty queue means the pipeline is
  // empty. The extra wait after that is margin.
  task automatic settle();
    req_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (RSP_LATENCY + 2) @(posedge clk);
  endtask

  // Valid stays high across back-to-back writes. set_sizes lowers it after
  // the last write.
  task automatic write_cfg(input logic [7:0] idx, input logic [CfgWidth-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < NumCfg) group_size[idx[1:0]] = val;
  endtask

  // Writes all four group sizes, then one write to an index that has no
  // register. The block must ignore that last write.
  task automatic set_sizes(input logic [CfgWidth-1:0] s0, input logic [CfgWidth-1:0] s1,
                           input logic [CfgWidth-1:0] s2, input logic [CfgWidth-1:0] s3,
                           input logic [7:0] junk_idx, input logic [CfgWidth-1:0] junk_val);
    write_cfg(CFG_GROUP0_SLOTS, s0);
    write_cfg(CFG_GROUP1_SLOTS, s1);
    write_cfg(CFG_GROUP2_SLOTS, s2);
    write_cfg(CFG_GROUP3_SLOTS, s3);
    write_cfg(junk_idx, junk_val);
    cfg_valid <= 1'b0;
  endtask

  // Claims at the reset sizes (5, 6, 4, 3). Covers the key range limits, and
  // each refusal reason in its order of priority.
  task automatic test_claim_checks();
    send_req(OP_CLAIM, KEY_EMPTY,                 2'd0, 3'd0);
    send_req(OP_CLAIM, KeyWidth'(KEY_MIN - 1'b1), 2'd0, 3'd0);
    send_req(OP_CLAIM, KeyWidth'(KEY_MAX + 1'b1), 2'd1, 3'd1);
    send_req(OP_CLAIM, '1,                        2'd3, 3'd7);
    send_req(OP_CLAIM, KEY_MIN,                   2'd0, 3'd0);
    send_req(OP_CLAIM, KEY_MAX,                   2'd3, 3'd2);
    send_req(OP_CLAIM, KEY_MIN,                   2'd1, 3'd0);
    send_req(OP_CLAIM, 17'd12345,                 2'd0, 3'd5);
    send_req(OP_CLAIM, 17'd12345,                 2'd1, 3'd7);
    send_req(OP_CLAIM, 17'd12345,                 2'd0, 3'd0);
    // The key is present and the location is bad. Present is reported.
    send_req(OP_CLAIM, KEY_MAX,                   2'd3, 3'd7);
  endtask

  // Search and release, hit and miss. Covers the unused opcode acting as a
  // search, and a release of a key that was just released.
  task automatic test_release_search();
    send_req(OP_SEARCH,  KEY_MAX,                   2'd0, 3'd0);
    send_req(OP_SEARCH,  17'd12345,                 2'd1, 3'd3);
    send_req(OP_UNUSED,  KEY_MIN,                   2'd2, 3'd6);
    send_req(OP_RELEASE, KEY_MIN,                   2'd0, 3'd0);
    send_req(OP_RELEASE, KEY_MIN,                   2'd3, 3'd7);
    send_req(OP_RELEASE, KeyWidth'(KEY_MIN - 1'b1), 2'd0, 3'd0);
    send_req(OP_SEARCH,  KEY_MIN,                   2'd0, 3'd0);
  endtask

  // Group sizes at the extremes: zero, above the maximum (saturates to the
  // maximum) and one. Keys stored beyond a shrunken size must still be found.
  task automatic test_group_sizes();
    settle();
    set_sizes('0, '0, '0, '0, CFG_UNUSED_FIRST, '1);
    send_req(OP_CLAIM,  17'd20000, 2'd0, 3'd0);
    send_req(OP_CLAIM,  17'd20000, 2'd3, 3'd0);
    send_req(OP_SEARCH, KEY_MAX,   2'd0, 3'd0);
    send_req(OP_CLAIM,  KEY_MAX,   2'd2, 3'd0);
    settle();
    set_sizes('1, '1, '1, '1, CFG_UNUSED_LAST, '0);
    send_req(OP_CLAIM, 17'd20000, 2'd2, 3'd6);
    send_req(OP_CLAIM, 17'd20000, 2'd2, 3'd5);
    send_req(OP_CLAIM, 17'd20001, 2'd0, 3'd5);
    settle();
    set_sizes(3'd1, 3'd1, 3'd1, 3'd1, CFG_UNUSED_LAST, '1);
    send_req(OP_CLAIM,  17'd30000, 2'd1, 3'd0);
    send_req(OP_CLAIM,  17'd30001, 2'd1, 3'd1);
    send_req(OP_SEARCH, 17'd20000, 2'd0, 3'd0);
  endtask

  // Random traffic in phases. Each phase has its own group sizes. Phases
  // alternate between more claims than releases and the reverse, so the table
  // repeatedly fills and drains. One phase runs with no gaps on either side.
  task automatic test_random_traffic();
    int                  pick;
    int                  claim_pct;
    logic [1:0]          op;
    logic [2:0]          slot;
    for (int i = 0; i < POOL_SIZE; i++)
      key_pool[i] = KeyWidth'($urandom_range(KEY_MIN, KEY_MAX));
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      if (phase == 0)
        set_sizes(3'd6, 3'd6, 3'd6, 3'd6, 8'($urandom_range(4, 255)), 3'($urandom));
      else if (phase == NUM_PHASES - 1)
        set_sizes(3'd1, 3'd1, 3'd1, 3'd1, 8'($urandom_range(4, 255)), 3'($urandom));
      else
        set_sizes(pick_size(), pick_size(), pick_size(), pick_size(),
                  8'($urandom_range(4, 255)), 3'($urandom));
      no_idle   = (phase == 3);
      claim_pct = (phase % 2 == 0) ? 45 : 25;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < claim_pct)           op = OP_CLAIM;
        else if (pick < claim_pct + 30) op = OP_RELEASE;
        else if (pick < claim_pct + 35) op = OP_UNUSED;
        else                            op = OP_SEARCH;
        if ($urandom_range(0, 9) == 0) slot = 3'($urandom_range(6, 7));
        else                           slot = 3'($urandom_range(0, 5));
        send_req(op, pick_key(), 2'($urandom_range(0, 3)), slot);
      end
      no_idle = 1'b0;
    end
  endtask

  // Response back-pressure. Stall and free stretches of random length, held
  // low through reset and through the phase that runs with no gaps.
  always @(posedge clk) begin
    if (rst || no_idle) begin
      rsp_stall     <= 1'b0;
      rsp_hold_left <= 0;
    end else if (rsp_hold_left != 0) begin
      rsp_hold_left <= rsp_hold_left - 1;
    end else if (rsp_stall) begin
      rsp_stall     <= 1'b0;
      rsp_hold_left <= pick_gap();
    end else if ($urandom_range(0, 2) == 0) begin
      rsp_stall     <= 1'b1;
      rsp_hold_left <= pick_gap();
    end
  end

  // Response checker. A response is taken at an edge where valid is high and
  // stall is low, and it must match the oldest prediction in every field.
  always @(posedge clk) begin : rsp_check
    ksl_rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp.size() == 0) begin
        $error("response arrived with no request outstanding");
        error_count++;
      end else begin
        want = expected_rsp.pop_front();
        if (rsp_data.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
          error_count++;
        end
        if (rsp_data.found_group !== want.found_group) begin
          $error("found_group: expected %0d, actual %0d",
                 want.found_group, rsp_data.found_group);
          error_count++;
        end
        if (rsp_data.found_slot !== want.found_slot) begin
          $error("found_slot: expected %0d, actual %0d",
                 want.found_slot, rsp_data.found_slot);
          error_count++;
        end
      end
    end
  end

  initial begin
    group_size[0] = GROUP0_SLOTS_RST;
    group_size[1] = GROUP1_SLOTS_RST;
    group_size[2] = GROUP2_SLOTS_RST;
    group_size[3] = GROUP3_SLOTS_RST;
    for (int i = 0; i < NUM_ENTRIES; i++) table_keys[i] = KEY_EMPTY;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_claim_checks();
    test_release_search();
    test_group_sizes();
    test_random_traffic();
    settle();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog. The slowest correct run needs only a small part of this time.
  initial begin
    #(20_000_000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
